FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_core; depends on nothing.
package spq_pkg;

  typedef logic [47:0] spq_key_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] key_time;
    logic [15:0] key_arrival;
    logic [15:0] key_pid;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] top_time;
    logic [15:0] top_arrival;
    logic [15:0] top_pid;
    logic [4:0]  held_count;
  } spq_out_t;

  // record travelling down the chain during an insert
  typedef struct packed {
    logic     valid;
    logic     placed;
    spq_key_t key;
  } spq_token_t;

  typedef struct packed {
    logic shift;
    logic highest_first;
  } spq_cell_ctrl_t;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_PEEK   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic REG_HIGHEST_FIRST  = 1'b0;
  localparam logic REG_CAPACITY_LIMIT = 1'b1;

endpackage

FILE: src/spq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the queue chain: holds one record and a travelling token.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_cell_ctrl_t ctrl,
  input  logic [CW-1:0]  count,
  input  spq_token_t     tok_in,
  input  spq_key_t       right_key,
  output spq_token_t     tok_out,
  output spq_key_t       key_out
);

  spq_token_t tok_r;
  spq_key_t   entry_r;
  spq_key_t   entry_nxt;
  logic       landing;
  logic       wins;

  assign landing = (CW'(IDX) == count);
  assign wins    = ctrl.highest_first ? (tok_r.key >= entry_r) : (tok_r.key <= entry_r);
  assign key_out = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    tok_out   = '0;
    if (ctrl.shift) begin
      entry_nxt = right_key;
    end else if (tok_r.valid) begin
      if (landing) begin
        entry_nxt = tok_r.key;
      end else if (tok_r.placed || wins) begin
        // take the token's record, push ours onward unconditionally
        entry_nxt      = tok_r.key;
        tok_out.valid  = 1'b1;
        tok_out.placed = 1'b1;
        tok_out.key    = entry_r;
      end else begin
        tok_out = tok_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
    entry_r <= entry_nxt;
  end

endmodule

FILE: src/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// Sorted priority queue built as a chain of DEPTH record cells.
// Every request's result is registered and shown in the cycle after acceptance.
// Remove and peek finish on acceptance; an insert walks its record down the chain
// one cell a cycle and holds the input until it lands after the records held before it.
// Synchronous active-low reset empties the queue and sets highest-first, capacity 16.
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  spq_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output spq_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  logic           highest_first_r;
  logic [4:0]     capacity_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  step_r, step_nxt;
  logic           walking_r, walking_nxt;
  logic           out_valid_r, out_valid_nxt;
  spq_out_t       out_data_r, out_data_nxt;

  logic           in_accept;
  logic           cfg_write;
  logic [LW-1:0]  lim;
  logic           full;
  logic           empty;
  logic           do_shift;
  spq_cell_ctrl_t ctrl;
  spq_token_t     launch;
  spq_token_t     tok   [DEPTH];
  spq_key_t       keys  [DEPTH];
  spq_key_t       front;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = walking_r || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (paddr[2])
      REG_HIGHEST_FIRST:  prdata = {31'd0, highest_first_r};
      REG_CAPACITY_LIMIT: prdata = {27'd0, capacity_r};
      default:            prdata = '0;
    endcase
  end

  // clamp the capacity to 1..DEPTH
  always_comb begin
    lim = LW'(capacity_r);
    if (lim == '0) begin
      lim = LW'(1);
    end else if (lim > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end
  end

  assign full     = LW'(count_r) >= lim;
  assign empty    = (count_r == '0);
  assign front    = keys[0];
  assign do_shift = in_accept && (in_data.func == FUNC_REMOVE) && !empty;

  assign ctrl.shift         = do_shift;
  assign ctrl.highest_first = highest_first_r;

  always_comb begin
    launch       = '0;
    launch.valid = in_accept && (in_data.func == FUNC_INSERT) && !full;
    launch.key   = {in_data.key_time, in_data.key_arrival, in_data.key_pid};
  end

  always_comb begin
    count_nxt     = count_r;
    step_nxt      = step_r;
    walking_nxt   = walking_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (walking_r) begin
      // record lands in the first free cell: finish there
      if (step_r == count_r) begin
        walking_nxt = 1'b0;
        count_nxt   = count_r + CW'(1);
      end else begin
        step_nxt = step_r + CW'(1);
      end
    end

    if (in_accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt.held_count = 5'(count_r);
      case (in_data.func)
        FUNC_INSERT: begin
          if (full) begin
            out_data_nxt.status = STATUS_FULL;
          end else begin
            out_data_nxt.status     = STATUS_OK;
            out_data_nxt.held_count = 5'(count_r + CW'(1));
            walking_nxt             = 1'b1;
            step_nxt                = '0;
          end
        end
        FUNC_REMOVE, FUNC_PEEK: begin
          if (empty) begin
            out_data_nxt.status = STATUS_EMPTY;
          end else begin
            out_data_nxt.status      = STATUS_OK;
            out_data_nxt.top_time    = front[47:32];
            out_data_nxt.top_arrival = front[31:16];
            out_data_nxt.top_pid     = front[15:0];
            if (in_data.func == FUNC_REMOVE) begin
              count_nxt               = count_r - CW'(1);
              out_data_nxt.held_count = 5'(count_r - CW'(1));
            end
          end
        end
        default: begin
          out_data_nxt.status = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_first_r <= 1'b1;
      capacity_r      <= 5'd16;
      count_r         <= '0;
      step_r          <= '0;
      walking_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          REG_HIGHEST_FIRST:  highest_first_r <= pwdata[0];
          REG_CAPACITY_LIMIT: capacity_r      <= pwdata[4:0];
          default:            capacity_r      <= capacity_r;
        endcase
      end
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      walking_r   <= walking_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_token_t tok_src;
    spq_key_t   right_src;

    if (i == 0) begin : g_head
      assign tok_src = launch;
    end else begin : g_body
      assign tok_src = tok[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_src = keys[i];
    end else begin : g_inner
      assign right_src = keys[i+1];
    end

    spq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .count     (count_r),
      .tok_in    (tok_src),
      .right_key (right_src),
      .tok_out   (tok[i]),
      .key_out   (keys[i])
    );
  end

endmodule

FILE: verif/sorted_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_core: directed and random requests are
// checked against a sorted-array predictor kept in the bench, with random stalls on both sides.
// Depends on spq_pkg and the core RTL.
module sorted_priority_queue_core_tb import spq_pkg::*;;

  localparam int DEPTH = 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_HIGHEST_FIRST  = {REG_HIGHEST_FIRST, 2'b00};
  localparam logic [2:0] ADDR_CAPACITY_LIMIT = {REG_CAPACITY_LIMIT, 2'b00};
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 190;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  spq_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  spq_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  spq_key_t    held_keys [DEPTH];
  int unsigned held_total;
  logic        mode_highest;
  logic [4:0]  cap_reg;
  spq_out_t    pending_results [$];
  int unsigned mismatches;
  bit          send_steady;
  bit          recv_steady;

  sorted_priority_queue_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Apply one request to the predicted queue and return the result it should give.
  function automatic spq_out_t queue_step(spq_in_t req);
    spq_out_t    res;
    spq_key_t    fresh;
    spq_key_t    top;
    int unsigned lim;
    int unsigned spot;
    res = '0;
    res.status = STATUS_OK;
    top = '0;
    fresh = {req.key_time, req.key_arrival, req.key_pid};
    lim = cap_reg;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    case (req.func)
      FUNC_INSERT: begin
        if (held_total >= lim) begin
          res.status = STATUS_FULL;
        end else begin
          spot = 0;
          while (spot < held_total &&
                 !(mode_highest ? fresh >= held_keys[spot] : fresh <= held_keys[spot]))
            spot++;
          for (int i = held_total; i > spot; i--) held_keys[i] = held_keys[i - 1];
          held_keys[spot] = fresh;
          held_total++;
        end
      end
      FUNC_REMOVE, FUNC_PEEK: begin
        if (held_total == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          top = held_keys[0];
          if (req.func == FUNC_REMOVE) begin
            for (int i = 0; i + 1 < held_total; i++) held_keys[i] = held_keys[i + 1];
            held_total--;
          end
        end
      end
      default: ;
    endcase
    {res.top_time, res.top_arrival, res.top_pid} = top;
    res.held_count = held_total[4:0];
    return res;
  endfunction

  // small ranges give many equal and near-equal keys
  function automatic logic [15:0] key_part(int unsigned style);
    case (style)
      0: return 16'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic spq_in_t random_request(logic [1:0] func);
    spq_in_t     req;
    int unsigned style;
    style = $urandom_range(0, 4);
    req.func = func;
    req.key_time = key_part(style);
    req.key_arrival = key_part(style);
    req.key_pid = key_part(style);
    return req;
  endfunction

  task automatic send_request(spq_in_t req);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(queue_step(req));
  endtask

  // Drop valid, let every result come back, then give the chain time to go quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_HIGHEST_FIRST) mode_highest = value[0];
    else cap_reg = value[4:0];
    // read it straight back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $display("%0t register %0d readback expected %h actual %h", $time, addr, value, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic configure(logic mode, logic [4:0] cap);
    wait_idle();
    write_register(ADDR_HIGHEST_FIRST, {31'b0, mode});
    write_register(ADDR_CAPACITY_LIMIT, {27'b0, cap});
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall per result, compare against the oldest prediction
  initial begin
    spq_out_t    got;
    spq_out_t    want;
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = recv_steady ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("top_time", want.top_time, got.top_time);
        check_field("top_arrival", want.top_arrival, got.top_arrival);
        check_field("top_pid", want.top_pid, got.top_pid);
        check_field("held_count", want.held_count, got.held_count);
      end
    end
  end

  task automatic test_empty_queue();
    send_request({FUNC_REMOVE, 48'h0});
    send_request({FUNC_PEEK, 48'h0});
    send_request({FUNC_UNUSED, 48'hFFFF_FFFF_FFFF});
  endtask

  task automatic test_extreme_keys();
    send_request({FUNC_INSERT, 48'h0000_0000_0000});
    send_request({FUNC_INSERT, 48'hFFFF_FFFF_FFFF});
    send_request({FUNC_INSERT, 48'h0000_FFFF_FFFF});
    send_request({FUNC_INSERT, 48'hFFFF_0000_0000});
    send_request({FUNC_INSERT, 48'hFFFF_FFFF_FFFF});
    send_request({FUNC_PEEK, 48'h0});
    repeat (6) send_request({FUNC_REMOVE, 48'h0});
  endtask

  task automatic test_capacity_edges();
    configure(1'b1, 5'd1);
    send_request({FUNC_INSERT, 48'h1234_5678_9ABC});
    send_request({FUNC_INSERT, 48'h0000_0000_0001});
    send_request({FUNC_REMOVE, 48'h0});
    configure(1'b0, 5'd0);
    send_request({FUNC_INSERT, 48'h0001_0002_0003});
    send_request({FUNC_INSERT, 48'h0001_0002_0004});
    // lower the limit under the held count: inserts refused until it drains
    configure(1'b0, 5'd16);
    send_request({FUNC_INSERT, 48'h0001_0002_0002});
    configure(1'b0, 5'd1);
    send_request({FUNC_INSERT, 48'h0000_0000_0000});
    send_request({FUNC_REMOVE, 48'h0});
    send_request({FUNC_INSERT, 48'h0000_0000_0000});
    send_request({FUNC_REMOVE, 48'h0});
    send_request({FUNC_INSERT, 48'h0000_0000_0005});
  endtask

  // Phases keep their records across settings changes, so mode flips and
  // lowered limits land on a part-full queue.
  task automatic test_random_traffic();
    logic        mode;
    logic [4:0]  cap;
    logic [1:0]  func;
    int unsigned pick;
    bit          fill;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin mode = 1'b1; cap = 5'd16; end
        1: begin mode = 1'b0; cap = 5'd16; end
        2: begin mode = 1'b1; cap = 5'd1; end
        3: begin mode = 1'b0; cap = 5'd31; end
        4: begin mode = 1'b1; cap = 5'd0; end
        default: begin
          mode = 1'($urandom_range(0, 1));
          cap = 5'($urandom_range(0, 31));
        end
      endcase
      configure(mode, cap);
      send_steady = (phase % 4 == 3);
      recv_steady = (phase % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        fill = ((n / 40) % 2 == 0);
        pick = $urandom_range(0, 99);
        if (pick < 3) func = FUNC_UNUSED;
        else if (pick < 15) func = FUNC_PEEK;
        else if (pick < (fill ? 75 : 35)) func = FUNC_INSERT;
        else func = FUNC_REMOVE;
        send_request(random_request(func));
      end
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    held_total = 0;
    mode_highest = 1'b1;
    cap_reg = 5'd16;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_extreme_keys();
    test_capacity_edges();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
